FILE: design/msf_pkg.sv
// msf_pkg: shared types and constants for the moving average stability filter
// no dependencies; imported by msf_div, msf_core and the top level
package msf_pkg;

  localparam int SAMPLE_W           = 32;
  localparam int LIMIT_W            = 31;
  localparam int DEFAULT_WINDOW_LEN = 8;
  localparam int MAX_WINDOW_LEN     = 64;
  // remainder of a sample by the window length, sized for the largest window
  localparam int REM_W              = $clog2(MAX_WINDOW_LEN);

  localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = LIMIT_W'(20);

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  // item after the divide stages: sample = quo * window_len + rem, 0 <= rem < window_len
  typedef struct packed {
    cmd_t                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] quo;
    logic [REM_W-1:0]           rem;
  } msf_item_t;

endpackage

FILE: design/msf_div.sv
// msf_div: input register and two stages that split each sample into
// floor quotient and remainder by the window length (reciprocal multiply)
// depends on msf_pkg
module msf_div import msf_pkg::*; #(
  parameter int WINDOW_LEN = DEFAULT_WINDOW_LEN
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cmd,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output msf_item_t                  dn_item
);

  localparam int RW    = $clog2(WINDOW_LEN);
  localparam int MAG_W = SAMPLE_W - 1;
  localparam int PW    = MAG_W + SAMPLE_W;
  localparam int SHIFT = MAG_W + RW;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1)
                                       / 64'(WINDOW_LEN);
  localparam logic [SAMPLE_W-1:0] RECIP = RECIP_FULL[SAMPLE_W-1:0];
  localparam logic [MAG_W-1:0]    N_MAG = MAG_W'(WINDOW_LEN);
  localparam logic [RW-1:0]       N_M1  = RW'(WINDOW_LEN - 1);

  // stage 0: input register
  logic                       s0_valid;
  cmd_t                       s0_cmd;
  logic signed [SAMPLE_W-1:0] s0_sample;
  // stage 1: quotient of the magnitude
  logic                       s1_valid;
  cmd_t                       s1_cmd;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic                       s1_neg;
  logic [MAG_W-1:0]           s1_mag;
  logic [MAG_W-1:0]           s1_quo;

  logic             s0_ready;
  logic             s1_ready;
  logic             s2_ready;
  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [PW-1:0]    prod;
  logic [MAG_W-1:0] quo_mag;
  logic [MAG_W-1:0] quo_times_n;
  logic [MAG_W-1:0] rem_wide;
  logic [RW-1:0]    rem_mag;
  logic [RW-1:0]    rem_floor;
  msf_item_t        item_next;

  assign s2_ready = !dn_valid || dn_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign s0_ready = !s0_valid || s1_ready;
  assign in_ready = s0_ready;

  // negative samples use ~s, which is non-negative; floor quotient is then ~q
  always_comb begin
    neg     = s0_sample[SAMPLE_W-1];
    mag     = neg ? ~s0_sample[MAG_W-1:0] : s0_sample[MAG_W-1:0];
    prod    = {{SAMPLE_W{1'b0}}, mag} * {{MAG_W{1'b0}}, RECIP};
    quo_mag = MAG_W'(prod >> SHIFT);
  end

  always_comb begin
    quo_times_n       = s1_quo * N_MAG;
    rem_wide          = s1_mag - quo_times_n;
    rem_mag           = rem_wide[RW-1:0];
    rem_floor         = s1_neg ? (N_M1 - rem_mag) : rem_mag;
    item_next.cmd     = s1_cmd;
    item_next.sample  = s1_sample;
    item_next.quo     = s1_neg ? ~$signed({1'b0, s1_quo}) : $signed({1'b0, s1_quo});
    item_next.rem     = REM_W'(rem_floor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (s0_ready) s0_valid <= in_valid;
      if (s1_ready) s1_valid <= s0_valid;
      if (s2_ready) dn_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready) begin
      s0_cmd    <= cmd_t'(cmd);
      s0_sample <= sample;
    end
    if (s1_ready) begin
      s1_cmd    <= s0_cmd;
      s1_sample <= s0_sample;
      s1_neg    <= neg;
      s1_mag    <= mag;
      s1_quo    <= quo_mag;
    end
    if (s2_ready) begin
      dn_item <= item_next;
    end
  end

endmodule

FILE: design/msf_core.sv
// msf_core: window state, sample ring memory, settling counter, limit
// register and result register
// depends on msf_pkg; fed by msf_div
module msf_core import msf_pkg::*; #(
  parameter int WINDOW_LEN = DEFAULT_WINDOW_LEN
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [LIMIT_W-1:0]         cfg_wr_data,
  input  logic                       dn_valid,
  output logic                       dn_ready,
  input  msf_item_t                  dn_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] average,
  output logic                       is_stable
);

  localparam int RW  = $clog2(WINDOW_LEN);
  localparam int QSW = SAMPLE_W + 1;
  localparam int CW  = $clog2(WINDOW_LEN + 2);
  localparam int DW  = SAMPLE_W + 1;
  localparam logic [RW-1:0]        LAST_SLOT = RW'(WINDOW_LEN - 1);
  localparam logic [CW-1:0]        CNT_MAX   = CW'(WINDOW_LEN + 1);
  localparam logic signed [RW+1:0] N_S       = (RW+2)'(WINDOW_LEN);

  // ring holds each sample as floor quotient and remainder
  logic signed [SAMPLE_W-1:0] ring_q [WINDOW_LEN];
  logic [RW-1:0]              ring_r [WINDOW_LEN];
  logic signed [SAMPLE_W-1:0] rd_q;
  logic [RW-1:0]              rd_r;
  logic [WINDOW_LEN-1:0]      slot_vld;

  logic [LIMIT_W-1:0]         error_limit;
  logic [RW-1:0]              write_slot;
  logic signed [QSW-1:0]      sum_q;
  logic [RW-1:0]              sum_r;
  logic signed [SAMPLE_W-1:0] current_mean;
  logic [CW-1:0]              match_count;

  logic                       process;
  logic                       push;
  logic                       clear;
  logic signed [SAMPLE_W-1:0] old_q;
  logic [RW-1:0]              old_r;
  logic [RW-1:0]              new_r;
  logic signed [RW+1:0]       r_tot;
  logic signed [RW+1:0]       r_fix;
  logic signed [1:0]          carry;
  logic [RW-1:0]              write_slot_next;
  logic signed [QSW-1:0]      sum_q_next;
  logic [RW-1:0]              sum_r_next;
  logic                       round_up;
  logic signed [QSW-1:0]      mean_full;
  logic signed [SAMPLE_W-1:0] mean_next;
  logic signed [DW-1:0]       diff;
  logic [DW-1:0]              abs_diff;
  logic                       steady;
  logic [CW-1:0]              match_count_next;

  assign dn_ready = !out_valid || out_ready;
  assign process  = dn_valid && dn_ready;
  assign push     = process && (dn_item.cmd == CMD_PUSH);
  assign clear    = process && (dn_item.cmd == CMD_CLEAR);

  always_comb begin
    old_q = slot_vld[write_slot] ? rd_q : '0;
    old_r = slot_vld[write_slot] ? rd_r : '0;
    new_r = dn_item.rem[RW-1:0];

    // remainder sum kept in [0, N), overflow moves into the quotient sum
    r_tot = $signed({2'b00, sum_r}) + $signed({2'b00, new_r}) - $signed({2'b00, old_r});
    if (r_tot < 0) begin
      r_fix = r_tot + N_S;
      carry = -2'sd1;
    end else if (r_tot >= N_S) begin
      r_fix = r_tot - N_S;
      carry = 2'sd1;
    end else begin
      r_fix = r_tot;
      carry = 2'sd0;
    end
    sum_r_next = r_fix[RW-1:0];
    sum_q_next = sum_q + QSW'(dn_item.quo) - QSW'(old_q) + QSW'(carry);

    // floor to truncation toward zero
    round_up  = (sum_q_next < 0) && (sum_r_next != '0);
    mean_full = sum_q_next + $signed({{(QSW-1){1'b0}}, round_up});
    mean_next = mean_full[SAMPLE_W-1:0];

    diff     = DW'(current_mean) - DW'(dn_item.sample);
    abs_diff = diff[DW-1] ? DW'(-diff) : DW'(diff);
    steady   = abs_diff <= {{(DW-LIMIT_W){1'b0}}, error_limit};

    if (!steady) begin
      match_count_next = '0;
    end else if (match_count == CNT_MAX) begin
      match_count_next = match_count;
    end else begin
      match_count_next = match_count + 1'b1;
    end

    if (rst) begin
      write_slot_next = '0;
    end else if (push) begin
      write_slot_next = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
    end else begin
      write_slot_next = write_slot;
    end
  end

  // ring memory: one write at the current slot, registered read of the next one
  always_ff @(posedge clk) begin
    if (push) begin
      ring_q[write_slot] <= dn_item.quo;
      ring_r[write_slot] <= new_r;
    end
    rd_q <= ring_q[write_slot_next];
    rd_r <= ring_r[write_slot_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_limit  <= DEFAULT_LIMIT;
      write_slot   <= '0;
      slot_vld     <= '0;
      sum_q        <= '0;
      sum_r        <= '0;
      current_mean <= '0;
      match_count  <= '0;
      out_valid    <= 1'b0;
    end else begin
      write_slot <= write_slot_next;
      if (cfg_wr_en) begin
        error_limit <= cfg_wr_data;
      end else if (clear && (error_limit == '0)) begin
        error_limit <= DEFAULT_LIMIT;
      end
      if (clear) begin
        slot_vld     <= '0;
        sum_q        <= '0;
        sum_r        <= '0;
        current_mean <= '0;
        match_count  <= '0;
      end else if (push) begin
        slot_vld[write_slot] <= 1'b1;
        sum_q                <= sum_q_next;
        sum_r                <= sum_r_next;
        current_mean         <= mean_next;
        match_count          <= match_count_next;
      end
      if (process) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      average   <= '0;
      is_stable <= 1'b0;
    end else if (push) begin
      average   <= mean_next;
      is_stable <= (match_count_next == CNT_MAX);
    end
  end

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    clear |=> (average == '0) && !is_stable && (match_count == '0))
    else $error("clear item did not give a zero result");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    process |=> (average == current_mean) && (is_stable == (match_count == CNT_MAX)))
    else $error("result register differs from window state");

  a_rem_sum_range: assert property (@(posedge clk) disable iff (rst)
    sum_r <= LAST_SLOT)
    else $error("remainder sum left its range");

  a_slot_advance: assert property (@(posedge clk) disable iff (rst)
    (push && (write_slot != LAST_SLOT)) |=> (write_slot == $past(write_slot) + 1'b1))
    else $error("write slot did not advance on a pushed sample");

endmodule

FILE: design/moving_average_stability_filter.sv
// moving_average_stability_filter: top level of the boxcar average with settling detect
// instantiates msf_div and msf_core; depends on msf_pkg
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   input    | in_valid / in_ready    | cmd, sample
//   result   | out_valid / out_ready  | average, is_stable
//   config   | cfg_wr_en (no wait)    | cfg_wr_data -> error_limit
//
// one item per cycle sustained while out_ready is held high; a result is valid once its item
// has passed the input register, two divide stages and the result register
// the window state updates as each item is taken in msf_core, so items flow back to back
// stalls on out_ready back up through the stages; a stage empties into a free one
// reset clears all control state, the window and sets error_limit to 20; no clearing pass
module moving_average_stability_filter import msf_pkg::*; #(
  parameter int WINDOW_LEN = DEFAULT_WINDOW_LEN
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [LIMIT_W-1:0]         cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cmd,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] average,
  output logic                       is_stable
);

  logic      dn_valid;
  logic      dn_ready;
  msf_item_t dn_item;

  msf_div #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sample   (sample),
    .dn_valid (dn_valid),
    .dn_ready (dn_ready),
    .dn_item  (dn_item)
  );

  msf_core #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .dn_valid    (dn_valid),
    .dn_ready    (dn_ready),
    .dn_item     (dn_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .average     (average),
    .is_stable   (is_stable)
  );

endmodule
